// ===== hw/rtl/mosd_pkg.sv =====
// Package: types and codes shared by the ModRM/SIB operand decoder.
`timescale 1ns / 1ps
`default_nettype none
package mosd_pkg;

  // operand kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_INT   = 2'd1;
  localparam logic [1:0] KIND_VEC   = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  // register size codes
  localparam logic [2:0] SZ_BYTE_LO = 3'd0;
  localparam logic [2:0] SZ_BYTE_HI = 3'd1;
  localparam logic [2:0] SZ_WORD    = 3'd2;
  localparam logic [2:0] SZ_DWORD   = 3'd3;
  localparam logic [2:0] SZ_QWORD   = 3'd4;
  localparam logic [2:0] SZ_MMX     = 3'd5;
  localparam logic [2:0] SZ_XMM     = 3'd6;
  localparam logic [2:0] SZ_OTHER   = 3'd7;

  // addressing forms
  localparam logic [1:0] AM_INDIRECT = 2'd0;
  localparam logic [1:0] AM_RIPREL   = 2'd1;
  localparam logic [1:0] AM_ABS      = 2'd2;
  localparam logic [1:0] AM_DIRECT   = 2'd3;

  // mod field values
  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  // special rm / sib encodings
  localparam logic [2:0] RM_SIB      = 3'd4;
  localparam logic [2:0] RM_DISP32   = 3'd5;
  localparam logic [2:0] IDX_NONE    = 3'd4;

  localparam logic [4:0] NO_REG = 5'd16;

  // segment codes
  localparam logic [2:0] SEG_NONE    = 3'd0;
  localparam logic [2:0] SEG_DEFAULT = 3'd1;
  localparam logic [2:0] SEG_FS      = 3'd4;
  localparam logic [2:0] SEG_GS      = 3'd5;

  // displacement lengths
  localparam logic [2:0] DISP_0 = 3'd0;
  localparam logic [2:0] DISP_1 = 3'd1;
  localparam logic [2:0] DISP_4 = 3'd4;

  typedef struct packed {
    logic [7:0] modrm;
    logic [7:0] sib;
    logic [1:0] operand_kind;
    logic [3:0] base_length;
    logic [3:0] rex_bits;
    logic       rex_present;
    logic [6:0] prefix_flags;
  } in_t;

  typedef struct packed {
    logic [3:0] reg_index;
    logic [2:0] reg_size;
    logic [1:0] addressing;
    logic [4:0] rm_index;
    logic [2:0] rm_size;
    logic [4:0] index_reg;
    logic [1:0] scale_log2;
    logic [2:0] disp_bytes;
    logic       sib_present;
    logic [2:0] segment;
    logic [4:0] advance;
  } out_t;

  // stage 1 -> stage 2
  typedef struct packed {
    logic       valid;
    logic [1:0] mod;
    logic [2:0] rm;
    logic [7:0] sib;
    logic [1:0] kind;
    logic [3:0] blen;
    logic       rexp;
    logic       rx;
    logic       rb;
    logic       adsize;
    logic       fsp;
    logic       gsp;
    logic [3:0] reg_index;
    logic [2:0] reg_size;
    logic [2:0] pf_cnt;
  } s1_t;

  // stage 2 -> stage 3
  typedef struct packed {
    logic       valid;
    logic [3:0] reg_index;
    logic [2:0] reg_size;
    logic [1:0] addressing;
    logic [4:0] rm_index;
    logic [2:0] rm_size;
    logic [4:0] index_reg;
    logic [1:0] scale_log2;
    logic [2:0] disp_bytes;
    logic       sib_present;
    logic [2:0] segment;
    logic [3:0] blen;
    logic       rexp;
    logic [2:0] pf_cnt;
  } s2_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mosd_reg_dec.sv =====
// Stage 1: field split, REX masking, reg-field operand decode, prefix count.
`timescale 1ns / 1ps
`default_nettype none
module mosd_reg_dec (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  input  mosd_pkg::in_t  in_item,
  output mosd_pkg::s1_t  s1_o
);

  mosd_pkg::s1_t s1_r, s1_nxt;

  logic [3:0] rex;
  logic [2:0] reg_f;
  logic [6:0] pf;
  logic       opsize;

  always_comb begin
    rex    = in_item.rex_present ? in_item.rex_bits : 4'd0;
    reg_f  = in_item.modrm[5:3];
    pf     = in_item.prefix_flags;
    opsize = pf[0];

    s1_nxt        = '0;
    s1_nxt.valid  = in_valid;
    s1_nxt.mod    = in_item.modrm[7:6];
    s1_nxt.rm     = in_item.modrm[2:0];
    s1_nxt.sib    = in_item.sib;
    s1_nxt.kind   = in_item.operand_kind;
    s1_nxt.blen   = in_item.base_length;
    s1_nxt.rexp   = in_item.rex_present;
    s1_nxt.rx     = rex[1];
    s1_nxt.rb     = rex[0];
    s1_nxt.adsize = pf[1];
    s1_nxt.fsp    = pf[4];
    s1_nxt.gsp    = pf[5];
    s1_nxt.pf_cnt = 3'({2'b0, pf[0]} + {2'b0, pf[1]} + {2'b0, pf[2]} + {2'b0, pf[3]}
                     + {2'b0, pf[4]} + {2'b0, pf[5]} + {2'b0, pf[6]});
    s1_nxt.reg_index = {rex[2], reg_f};

    case (in_item.operand_kind)
      mosd_pkg::KIND_BYTE: begin
        // AH..BH only exist without REX
        if (!in_item.rex_present && reg_f[2]) begin
          s1_nxt.reg_size  = mosd_pkg::SZ_BYTE_HI;
          s1_nxt.reg_index = {2'b00, reg_f[1:0]};
        end else begin
          s1_nxt.reg_size = mosd_pkg::SZ_BYTE_LO;
        end
      end
      mosd_pkg::KIND_INT: begin
        if (opsize)      s1_nxt.reg_size = mosd_pkg::SZ_WORD;
        else if (rex[3]) s1_nxt.reg_size = mosd_pkg::SZ_QWORD;
        else             s1_nxt.reg_size = mosd_pkg::SZ_DWORD;
      end
      mosd_pkg::KIND_VEC: begin
        s1_nxt.reg_size = (opsize || pf[2] || pf[3]) ? mosd_pkg::SZ_XMM : mosd_pkg::SZ_MMX;
      end
      default: begin
        s1_nxt.reg_size = mosd_pkg::SZ_OTHER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else begin
      s1_r.valid <= s1_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_r.mod       <= s1_nxt.mod;
    s1_r.rm        <= s1_nxt.rm;
    s1_r.sib       <= s1_nxt.sib;
    s1_r.kind      <= s1_nxt.kind;
    s1_r.blen      <= s1_nxt.blen;
    s1_r.rexp      <= s1_nxt.rexp;
    s1_r.rx        <= s1_nxt.rx;
    s1_r.rb        <= s1_nxt.rb;
    s1_r.adsize    <= s1_nxt.adsize;
    s1_r.fsp       <= s1_nxt.fsp;
    s1_r.gsp       <= s1_nxt.gsp;
    s1_r.reg_index <= s1_nxt.reg_index;
    s1_r.reg_size  <= s1_nxt.reg_size;
    s1_r.pf_cnt    <= s1_nxt.pf_cnt;
  end

  assign s1_o = s1_r;

endmodule
`default_nettype wire

// ===== hw/rtl/mosd_rm_dec.sv =====
// Stage 2: r/m operand decode (direct, SIB, RIP-relative, absolute forms).
`timescale 1ns / 1ps
`default_nettype none
module mosd_rm_dec (
  input  wire            clk,
  input  wire            rst_n,
  input  mosd_pkg::s1_t  s1_i,
  output mosd_pkg::s2_t  s2_o
);

  mosd_pkg::s2_t s2_r, s2_nxt;

  logic [2:0] bs;
  logic [2:0] ix;
  logic       nobase;
  logic       noindex;

  always_comb begin
    bs      = s1_i.sib[2:0];
    ix      = s1_i.sib[5:3];
    nobase  = (bs == mosd_pkg::RM_DISP32) && (s1_i.mod == mosd_pkg::MOD_NODISP);
    noindex = (ix == mosd_pkg::IDX_NONE) && !s1_i.rx;

    s2_nxt             = '0;
    s2_nxt.valid       = s1_i.valid;
    s2_nxt.reg_index   = s1_i.reg_index;
    s2_nxt.reg_size    = s1_i.reg_size;
    s2_nxt.blen        = s1_i.blen;
    s2_nxt.rexp        = s1_i.rexp;
    s2_nxt.pf_cnt      = s1_i.pf_cnt;
    s2_nxt.rm_index    = mosd_pkg::NO_REG;
    s2_nxt.index_reg   = mosd_pkg::NO_REG;
    s2_nxt.rm_size     = s1_i.adsize ? mosd_pkg::SZ_DWORD : mosd_pkg::SZ_QWORD;
    s2_nxt.segment     = mosd_pkg::SEG_NONE;
    s2_nxt.addressing  = mosd_pkg::AM_INDIRECT;
    s2_nxt.disp_bytes  = mosd_pkg::DISP_0;

    if (s1_i.mod == mosd_pkg::MOD_REG) begin
      s2_nxt.addressing = mosd_pkg::AM_DIRECT;
      if (s1_i.kind == mosd_pkg::KIND_BYTE) begin
        if (!s1_i.rexp && s1_i.rm[2]) begin
          s2_nxt.rm_size  = mosd_pkg::SZ_BYTE_HI;
          s2_nxt.rm_index = {3'b000, s1_i.rm[1:0]};
        end else begin
          s2_nxt.rm_size  = mosd_pkg::SZ_BYTE_LO;
          s2_nxt.rm_index = {1'b0, s1_i.rb, s1_i.rm};
        end
      end else begin
        s2_nxt.rm_size  = s1_i.reg_size;
        s2_nxt.rm_index = {1'b0, s1_i.rb, s1_i.rm};
      end
    end else begin
      case (s1_i.mod)
        mosd_pkg::MOD_DISP8:  s2_nxt.disp_bytes = mosd_pkg::DISP_1;
        mosd_pkg::MOD_DISP32: s2_nxt.disp_bytes = mosd_pkg::DISP_4;
        default:              s2_nxt.disp_bytes = mosd_pkg::DISP_0;
      endcase
      if (s1_i.rm == mosd_pkg::RM_SIB) begin
        s2_nxt.sib_present = 1'b1;
        s2_nxt.scale_log2  = s1_i.sib[7:6];
        if (nobase) s2_nxt.disp_bytes = mosd_pkg::DISP_4;
        else        s2_nxt.rm_index   = {1'b0, s1_i.rb, bs};
        if (!noindex) s2_nxt.index_reg = {1'b0, s1_i.rx, ix};
        if (nobase && noindex) begin
          s2_nxt.addressing = mosd_pkg::AM_ABS;
          s2_nxt.rm_size    = mosd_pkg::SZ_OTHER;
          s2_nxt.scale_log2 = 2'd0;
          if (s1_i.fsp)      s2_nxt.segment = mosd_pkg::SEG_FS;
          else if (s1_i.gsp) s2_nxt.segment = mosd_pkg::SEG_GS;
          else               s2_nxt.segment = mosd_pkg::SEG_DEFAULT;
        end
      end else if (s1_i.rm == mosd_pkg::RM_DISP32 && s1_i.mod == mosd_pkg::MOD_NODISP) begin
        s2_nxt.addressing = mosd_pkg::AM_RIPREL;
        s2_nxt.disp_bytes = mosd_pkg::DISP_4;
      end else begin
        s2_nxt.rm_index = {1'b0, s1_i.rb, s1_i.rm};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else begin
      s2_r.valid <= s2_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_r.reg_index   <= s2_nxt.reg_index;
    s2_r.reg_size    <= s2_nxt.reg_size;
    s2_r.addressing  <= s2_nxt.addressing;
    s2_r.rm_index    <= s2_nxt.rm_index;
    s2_r.rm_size     <= s2_nxt.rm_size;
    s2_r.index_reg   <= s2_nxt.index_reg;
    s2_r.scale_log2  <= s2_nxt.scale_log2;
    s2_r.disp_bytes  <= s2_nxt.disp_bytes;
    s2_r.sib_present <= s2_nxt.sib_present;
    s2_r.segment     <= s2_nxt.segment;
    s2_r.blen        <= s2_nxt.blen;
    s2_r.rexp        <= s2_nxt.rexp;
    s2_r.pf_cnt      <= s2_nxt.pf_cnt;
  end

  assign s2_o = s2_r;

endmodule
`default_nettype wire

// ===== hw/rtl/mosd_adv.sv =====
// Stage 3: instruction-pointer advance sum and the output register.
`timescale 1ns / 1ps
`default_nettype none
module mosd_adv (
  input  wire             clk,
  input  wire             rst_n,
  input  mosd_pkg::s2_t   s2_i,
  output logic            out_valid,
  output mosd_pkg::out_t  out_item
);

  logic           valid_r;
  mosd_pkg::out_t item_r, item_nxt;

  always_comb begin
    item_nxt             = '0;
    item_nxt.reg_index   = s2_i.reg_index;
    item_nxt.reg_size    = s2_i.reg_size;
    item_nxt.addressing  = s2_i.addressing;
    item_nxt.rm_index    = s2_i.rm_index;
    item_nxt.rm_size     = s2_i.rm_size;
    item_nxt.index_reg   = s2_i.index_reg;
    item_nxt.scale_log2  = s2_i.scale_log2;
    item_nxt.disp_bytes  = s2_i.disp_bytes;
    item_nxt.sib_present = s2_i.sib_present;
    item_nxt.segment     = s2_i.segment;
    // max 15 + 4 + 1 + 1 + 7 = 28, fits without wrap
    item_nxt.advance     = {1'b0, s2_i.blen} + {2'b00, s2_i.disp_bytes}
                         + {4'd0, s2_i.sib_present} + {4'd0, s2_i.rexp}
                         + {2'b00, s2_i.pf_cnt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= s2_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire

// ===== hw/rtl/modrm_sib_operand_decode.sv =====
// Throughput: one instruction per cycle; busy is always low.
// Three register stages: reg decode, r/m and SIB decode, advance sum.
// Each result is presented for exactly one cycle; the receiver cannot stall.
// Reset (synchronous, rst_n low) clears all stage valid bits; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module modrm_sib_operand_decode (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             start,
  output logic            busy,
  input  mosd_pkg::in_t   in_data,
  output logic            out_valid,
  output mosd_pkg::out_t  out_data
);

  mosd_pkg::s1_t s1;
  mosd_pkg::s2_t s2;

  assign busy = 1'b0;

  mosd_reg_dec u_reg_dec (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start),
    .in_item  (in_data),
    .s1_o     (s1)
  );

  mosd_rm_dec u_rm_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  mosd_adv u_adv (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2_i      (s2),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

  // every transfer in gives exactly one strobe, once it has passed the stage 1, stage 2 and output registers
  a_latency: assert property (@(posedge clk)
    (rst_n && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3))
      |-> (out_valid == $past(start && !busy, 3)))
    else $error("result strobe does not follow transfer by three cycles");

  a_abs_noregs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.addressing == mosd_pkg::AM_ABS)
      |-> (out_data.rm_index == mosd_pkg::NO_REG && out_data.index_reg == mosd_pkg::NO_REG))
    else $error("absolute form carries a base or index register");

  a_seg_only_abs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.addressing != mosd_pkg::AM_ABS)
      |-> (out_data.segment == mosd_pkg::SEG_NONE))
    else $error("segment set outside absolute form");

  a_direct_nomem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.addressing == mosd_pkg::AM_DIRECT)
      |-> (out_data.disp_bytes == mosd_pkg::DISP_0 && !out_data.sib_present
           && out_data.index_reg == mosd_pkg::NO_REG))
    else $error("register direct form with memory operand fields");

  a_scale_needs_sib: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.sib_present) |-> (out_data.scale_log2 == 2'd0))
    else $error("scale without SIB byte");

endmodule
`default_nettype wire
